// File: src/dkpt_pkg.sv
// Shared types, codes and a helper function for the dual-key peer table.
package dkpt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] OP_ADD        = 3'd0;
	localparam logic [2:0] OP_REMOVE_ID  = 3'd1;
	localparam logic [2:0] OP_REMOVE_MAC = 3'd2;
	localparam logic [2:0] OP_LOOKUP_ID  = 3'd3;
	localparam logic [2:0] OP_LOOKUP_MAC = 3'd4;
	localparam logic [2:0] OP_CLEAR      = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_EXISTS    = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] device_key;
		logic [47:0] mac_key;
	} req_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  slot_index;
		logic [15:0] found_id;
		logic [47:0] found_mac;
		logic [4:0]  entry_count;
	} rsp_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} pick_t;

	// Lowest set bit of a slot vector.
	function automatic pick_t lowest_set(input logic [TABLE_DEPTH-1:0] vec);
		pick_t r;
		r.hit = 1'b0;
		r.idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				r.hit = 1'b1;
				r.idx = IDX_W'(i);
			end
		end
		return r;
	endfunction

endpackage

// File: src/dkpt_ctrl.sv
// Controller state machine: request acceptance, execute step and result handshake.
module dkpt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dkpt_pkg::dp_cmd_t cmd
);
	import dkpt_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign cmd.load   = req_valid && (state_q == S_IDLE);
	// The result register may be reloaded in the same cycle its transaction completes.
	assign cmd.commit = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/dkpt_datapath.sv
// Datapath: request register, peer table storage, parallel match logic and result register.
module dkpt_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  dkpt_pkg::dp_cmd_t   cmd,
	input  dkpt_pkg::req_item_t req,
	output dkpt_pkg::rsp_item_t rsp
);
	import dkpt_pkg::*;

	req_item_t               req_q;
	rsp_item_t               rsp_q;
	logic [TABLE_DEPTH-1:0]  valid_q;
	logic [15:0]             entry_id_q  [TABLE_DEPTH];
	logic [47:0]             entry_mac_q [TABLE_DEPTH];
	logic [CNT_W-1:0]        used_q;

	logic [TABLE_DEPTH-1:0]  id_hit;
	logic [TABLE_DEPTH-1:0]  mac_hit;
	pick_t                   id_pick;
	pick_t                   mac_pick;
	pick_t                   free_pick;
	pick_t                   sel;
	logic                    key_zero;
	logic [2:0]              status;
	logic                    do_write;
	logic                    do_remove;
	logic                    do_clear;
	logic [CNT_W-1:0]        used_next;
	rsp_item_t               rsp_next;

	assign key_zero = (req_q.device_key == 16'd0);

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			id_hit[i]  = valid_q[i] && !key_zero && (entry_id_q[i] == req_q.device_key);
			mac_hit[i] = valid_q[i] && (entry_mac_q[i] == req_q.mac_key);
		end
	end

	assign id_pick   = lowest_set(id_hit);
	assign mac_pick  = lowest_set(mac_hit);
	assign free_pick = lowest_set(~valid_q);

	always_comb begin
		status    = ST_INVALID;
		sel       = '0;
		do_write  = 1'b0;
		do_remove = 1'b0;
		do_clear  = 1'b0;
		case (req_q.opcode)
			OP_ADD: begin
				if (key_zero) status = ST_INVALID;
				else if (id_pick.hit || mac_pick.hit) status = ST_EXISTS;
				else if (!free_pick.hit) status = ST_FULL;
				else begin
					status   = ST_OK;
					sel      = free_pick;
					do_write = 1'b1;
				end
			end
			OP_REMOVE_ID, OP_REMOVE_MAC: begin
				sel = (req_q.opcode == OP_REMOVE_ID) ? id_pick : mac_pick;
				if (sel.hit) begin
					status    = ST_OK;
					do_remove = 1'b1;
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			OP_LOOKUP_ID: begin
				if (key_zero) status = ST_INVALID;
				else begin
					sel    = id_pick;
					status = id_pick.hit ? ST_OK : ST_NOT_FOUND;
				end
			end
			OP_LOOKUP_MAC: begin
				sel    = mac_pick;
				status = mac_pick.hit ? ST_OK : ST_NOT_FOUND;
			end
			OP_CLEAR: begin
				status   = ST_OK;
				do_clear = 1'b1;
			end
			default: status = ST_INVALID;
		endcase
	end

	always_comb begin
		if (do_clear) used_next = '0;
		else if (do_write) used_next = used_q + CNT_W'(1);
		else if (do_remove) used_next = used_q - CNT_W'(1);
		else used_next = used_q;

		rsp_next.status      = status;
		rsp_next.entry_count = 5'(used_next);
		if (status == ST_OK && sel.hit) begin
			rsp_next.slot_index = 4'(sel.idx);
			// An added entry reports its new keys; others report what is stored.
			rsp_next.found_id   = do_write ? req_q.device_key : entry_id_q[sel.idx];
			rsp_next.found_mac  = do_write ? req_q.mac_key : entry_mac_q[sel.idx];
		end else begin
			rsp_next.slot_index = '0;
			rsp_next.found_id   = '0;
			rsp_next.found_mac  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
		end else if (cmd.commit) begin
			used_q <= used_next;
			if (do_clear) valid_q <= '0;
			else if (do_write) valid_q[sel.idx] <= 1'b1;
			else if (do_remove) valid_q[sel.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.commit) rsp_q <= rsp_next;
		if (cmd.commit && do_write) begin
			entry_id_q[sel.idx]  <= req_q.device_key;
			entry_mac_q[sel.idx] <= req_q.mac_key;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: src/dual_key_peer_table_top.sv
// An accepted request is captured in the request register; the execute step then compares all
// slots in parallel, writes back the table and loads the result register. No new request is
// accepted until the current one has committed its result.
// The execute step waits while a previous result is still stalled in the output register.
// Reset clears all slot valid bits, the entry count and the controller at once; key
// storage is not reset and there is no clearing pass.
module dual_key_peer_table_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  dkpt_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dkpt_pkg::rsp_item_t rsp
);
	import dkpt_pkg::*;

	dp_cmd_t cmd;

	dkpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	dkpt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
